### rtl/angle_frame_receiver_defines.svh
// Assertion macros shared by the angle frame receiver RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ANGLE_FRAME_RECEIVER_DEFINES_SVH
`define ANGLE_FRAME_RECEIVER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AFR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/afr_pkg.sv
// Package for the angle frame receiver: frame geometry, CRC constants and types.
// No dependencies; the front end, queue, back end and top-level modules import it.
package afr_pkg;

    localparam int ANGLE_COUNT = 5;
    localparam int FRAME_LEN   = 2 * ANGLE_COUNT + 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CRC_POLY     = 8'h07;
    localparam logic [7:0] CRC_INIT     = 8'h00;
    localparam logic [7:0] HEADER_RESET = 8'hAA;
    localparam logic [7:0] TAIL_RESET   = 8'h55;

    // Configuration register indexes.
    localparam logic CFG_HEADER = 1'b0;
    localparam logic CFG_TAIL   = 1'b1;

    typedef logic [FRAME_LEN-1:0][7:0] window_t;
    // Header, angle bytes and CRC byte; the tail byte is not kept.
    typedef logic [FRAME_LEN-2:0][7:0] frame_t;

    typedef struct packed {
        logic full;
        logic valid;
    } queue_stat_t;

    // CRC-8 over the header and the angle bytes, MSB first.
    function automatic logic [7:0] crc8_frame(frame_t f);
        logic [7:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < FRAME_LEN - 2; i++)
        begin
            crc = crc ^ f[i];
            for (int b = 0; b < 8; b++)
            begin
                if (crc[7])
                begin
                    crc = {crc[6:0], 1'b0} ^ CRC_POLY;
                end
                else
                begin
                    crc = {crc[6:0], 1'b0};
                end
            end
        end
        return crc;
    endfunction

endpackage

### rtl/afr_if.sv
// Stream interfaces for received bytes and for decoded frames.
// Does not depend on afr_pkg; the five angle ports are declared one by one.
interface afr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       burst_start;

    modport source (output valid, output rx_byte, output burst_start, input ready);
    modport sink   (input valid, input rx_byte, input burst_start, output ready);
endinterface

interface afr_out_if;
    logic        valid;
    logic        ready;
    logic        frame_status;
    logic [15:0] angle_0;
    logic [15:0] angle_1;
    logic [15:0] angle_2;
    logic [15:0] angle_3;
    logic [15:0] angle_4;

    modport source (output valid, output frame_status, output angle_0, output angle_1,
                    output angle_2, output angle_3, output angle_4, input ready);
    modport sink   (input valid, input frame_status, input angle_0, input angle_1,
                    input angle_2, input angle_3, input angle_4, output ready);
endinterface

### rtl/afr_front.sv
// Front end: burst tracking, sliding byte window and header/tail match detection.
// Depends on afr_pkg and afr_in_if; pushes matched frames into the queue.
module afr_front #(
    parameter int BURST_BYTES = 26
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          header_byte,
    input  logic [7:0]          tail_byte,
    afr_in_if.sink              rx,
    input  afr_pkg::queue_stat_t qstat,
    output logic                push,
    output afr_pkg::frame_t     push_frame
);
    import afr_pkg::*;

    localparam int CNT_W = $clog2(BURST_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(BURST_BYTES);
    localparam logic [CNT_W-1:0] CNT_FRAME = CNT_W'(FRAME_LEN);

    logic [CNT_W-1:0] cnt_reg;
    logic             matched_reg;
    window_t          win_reg;
    window_t          win_next;
    logic [CNT_W-1:0] cnt_eff;
    logic [CNT_W-1:0] cnt_inc;
    logic             matched_eff;
    logic             take;
    logic             room;
    logic             hit;

    assign rx.ready = !qstat.full;
    assign take     = rx.valid && rx.ready;

    always_comb
    begin
        cnt_eff     = rx.burst_start ? '0 : cnt_reg;
        matched_eff = rx.burst_start ? 1'b0 : matched_reg;
        room        = (cnt_eff != CNT_MAX);
        cnt_inc     = cnt_eff + CNT_W'(1);
        for (int i = 0; i < FRAME_LEN - 1; i++)
        begin
            win_next[i] = win_reg[i+1];
        end
        win_next[FRAME_LEN-1] = rx.rx_byte;
        hit = (cnt_inc >= CNT_FRAME) && !matched_eff &&
              (win_reg[1] == header_byte) && (rx.rx_byte == tail_byte);
    end

    assign push       = take && room && hit;
    assign push_frame = win_next[FRAME_LEN-2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            matched_reg <= 1'b0;
        end
        else if (take)
        begin
            if (room)
            begin
                cnt_reg     <= cnt_inc;
                matched_reg <= matched_eff || hit;
            end
            else
            begin
                cnt_reg     <= cnt_eff;
                matched_reg <= matched_eff;
            end
        end
    end

    // Window contents are only looked at once the burst has filled it.
    always_ff @(posedge clk)
    begin
        if (take && room)
        begin
            win_reg <= win_next;
        end
    end

endmodule

### rtl/afr_queue.sv
// Two-entry frame queue between the match front end and the decode back end.
// Depends on afr_pkg for the frame type and the queue status struct.
module afr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  afr_pkg::frame_t      push_frame,
    input  logic                 pop,
    output afr_pkg::frame_t      head,
    output afr_pkg::queue_stat_t qstat
);
    import afr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign qstat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign qstat.valid = (count_reg != '0);
    assign head        = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

### rtl/afr_back.sv
// Back end: CRC check and angle extraction into the output register.
// Depends on afr_pkg and afr_out_if; pops frames from the queue.
module afr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  afr_pkg::queue_stat_t qstat,
    input  afr_pkg::frame_t      head,
    output logic                 pop,
    afr_out_if.source            result
);
    import afr_pkg::*;

    logic                        valid_reg;
    logic                        status_reg;
    logic [ANGLE_COUNT-1:0][15:0] angle_reg;
    logic                        crc_ok;
    logic [ANGLE_COUNT-1:0][15:0] angle_next;

    assign pop = qstat.valid && (!valid_reg || result.ready);

    always_comb
    begin
        crc_ok = (crc8_frame(head) == head[FRAME_LEN-2]);
        for (int i = 0; i < ANGLE_COUNT; i++)
        begin
            angle_next[i] = crc_ok ? {head[2*i+2], head[2*i+1]} : 16'h0000;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= !crc_ok;
            angle_reg  <= angle_next;
        end
    end

    assign result.valid        = valid_reg;
    assign result.frame_status = status_reg;
    assign result.angle_0      = angle_reg[0];
    assign result.angle_1      = angle_reg[1];
    assign result.angle_2      = angle_reg[2];
    assign result.angle_3      = angle_reg[3];
    assign result.angle_4      = angle_reg[4];

endmodule

### rtl/angle_frame_receiver.sv
// Angle frame receiver: finds one header/tail framed packet per byte burst,
// checks its CRC-8 (polynomial 0x07, init 0) and reports five 16-bit angles.
// Bytes enter on the rx channel (rx_byte plus burst_start, which marks the
// first byte after a line-idle gap); decoded frames leave on the result channel.
// Configuration: cfg_we writes cfg_data into register cfg_index, where index 0
// is the header byte (reset 0xAA) and index 1 the tail byte (reset 0x55).
// Throughput is one byte per cycle while the queue is not full. The front end
// writes a frame into the queue in the transaction that carries its tail byte,
// and the CRC stage then pops it into the output register once that register
// is empty or its value is being taken.
// A two-entry queue sits between the match logic and the CRC stage; when the
// result receiver stalls, bytes are still taken until the queue is full, and
// rx.ready drops only then. A stalled result holds its value.
// Reset clears the burst state, the queue and the output valid, and restores
// the header and tail registers; the byte window needs no clearing because a
// burst must supply a full window of its own bytes before any match is tested.
// Bytes past BURST_BYTES in one burst are dropped without effect.
`include "angle_frame_receiver_defines.svh"

module angle_frame_receiver #(
    parameter int BURST_BYTES = 26
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    afr_in_if.sink     rx,
    afr_out_if.source  result
);
    import afr_pkg::*;

    logic [7:0]  header_reg;
    logic [7:0]  tail_reg;
    logic        push;
    logic        pop;
    frame_t      push_frame;
    frame_t      head;
    queue_stat_t qstat;
    logic        result_angles_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
            tail_reg   <= TAIL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER: header_reg <= cfg_data;
                CFG_TAIL:   tail_reg   <= cfg_data;
                default:    header_reg <= header_reg;
            endcase
        end
    end

    afr_front #(
        .BURST_BYTES (BURST_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .header_byte (header_reg),
        .tail_byte   (tail_reg),
        .rx          (rx),
        .qstat       (qstat),
        .push        (push),
        .push_frame  (push_frame)
    );

    afr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    afr_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .qstat  (qstat),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

    assign result_angles_zero = (result.angle_0 == 16'h0000) && (result.angle_1 == 16'h0000) &&
                                (result.angle_2 == 16'h0000) && (result.angle_3 == 16'h0000) &&
                                (result.angle_4 == 16'h0000);

    `AFR_ASSERT_SAME(a_no_overflow, push, !qstat.full, "frame pushed into a full queue")
    `AFR_ASSERT_SAME(a_pop_has_data, pop, qstat.valid, "frame popped from an empty queue")
    `AFR_ASSERT_SAME(a_bad_crc_zero, result.valid && result.frame_status, result_angles_zero, "CRC failure with nonzero angles")
    `AFR_ASSERT_NEXT(a_pop_loads_out, pop, result.valid, "popped frame did not reach the output")

endmodule
